// File: hw/rtl/pae_pkg.sv
// shared types and constants for the per-key adsr envelope block
// no dependencies

package pae_pkg;

    localparam int NUM_KEYS    = 256;
    localparam int KEY_W       = 8;
    localparam int VEL_W       = 8;
    localparam int LEVEL_W     = 8;
    localparam int PHASE_W     = 3;
    localparam int SETTING_W   = 8;
    localparam int CFG_IDX_W   = 2;
    localparam int QUEUE_DEPTH = 2;

    // only keys reachable by the index field get storage
    localparam int MEM_DEPTH = (NUM_KEYS < (1 << KEY_W)) ? NUM_KEYS : (1 << KEY_W);
    localparam int ADDR_W    = (MEM_DEPTH > 1) ? $clog2(MEM_DEPTH) : 1;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_ATTACK  = 2'd0,
        CFG_DECAY   = 2'd1,
        CFG_RELEASE = 2'd2
    } cfg_index_t;

    localparam logic [SETTING_W-1:0] ATTACK_RESET  = 8'd255;
    localparam logic [SETTING_W-1:0] DECAY_RESET   = 8'd128;
    localparam logic [SETTING_W-1:0] RELEASE_RESET = 8'd128;

    typedef enum logic [PHASE_W-1:0] {
        PH_REST    = 3'd0,
        PH_ATTACK  = 3'd1,
        PH_DECAY   = 3'd2,
        PH_SUSTAIN = 3'd3,
        PH_RELEASE = 3'd4
    } phase_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic [VEL_W-1:0] note_velocity;
    } in_item_t;

    typedef struct packed {
        logic [LEVEL_W-1:0] level;
        logic [PHASE_W-1:0] phase_out;
    } out_item_t;

    // classified item as it waits in the queue
    typedef struct packed {
        logic [KEY_W-1:0] key_index;
        logic [VEL_W-1:0] note_velocity;
        logic             in_range;
    } job_t;

    // per-key stored envelope
    typedef struct packed {
        phase_t             phase;
        logic [LEVEL_W-1:0] level;
        logic [VEL_W-1:0]   peak;
    } env_word_t;

endpackage

// File: hw/rtl/per_key_adsr_envelope.sv
// per-key adsr envelope generator, top level
// depends on pae_pkg, pae_front, pae_queue, pae_back
//
// Each input transaction advances one key's envelope (phase, intensity, latched
// velocity) by one frame tick and returns exactly one result transaction with the
// new level and phase. The back end takes one item at a time: it reads the key's
// entry from the single-port state memory as it takes the job, then updates and
// writes it back, taking no new job until the result is registered. An item passes
// the front register, a queue slot, the read register and the result register. The
// front register and a two-entry queue let inputs be taken while a result waits.
// All keys read as rest with zero level after reset, with no clearing pass. The
// user must write settings through the cfg port only while the block is idle; it
// does not enforce this. Index 0 attack, 1 decay, 2 release, others ignored.

module per_key_adsr_envelope import pae_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SETTING_W-1:0] cfg_data,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  in_item_t             s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    logic fq_valid;
    logic fq_ready;
    job_t fq_job;
    logic qb_valid;
    logic qb_ready;
    job_t qb_job;

    pae_front u_front (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .q_valid (fq_valid),
        .q_ready (fq_ready),
        .q_job   (fq_job)
    );

    pae_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (fq_valid),
        .push_ready (fq_ready),
        .push_job   (fq_job),
        .pop_valid  (qb_valid),
        .pop_ready  (qb_ready),
        .pop_job    (qb_job)
    );

    pae_back u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .q_valid   (qb_valid),
        .q_ready   (qb_ready),
        .q_job     (qb_job),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

endmodule

// File: hw/rtl/pae_front.sv
// front end: accepts input transactions and classifies the key index
// depends on pae_pkg

module pae_front import pae_pkg::*; (
    input  logic     aclk,
    input  logic     aresetn,
    input  logic     s_valid,
    output logic     s_ready,
    input  in_item_t s_data,
    output logic     q_valid,
    input  logic     q_ready,
    output job_t     q_job
);

    logic hold_valid_reg;
    job_t hold_reg;
    logic in_range;

    assign in_range = (32'(s_data.key_index) < 32'(NUM_KEYS));
    assign s_ready  = !hold_valid_reg || q_ready;
    assign q_valid  = hold_valid_reg;
    assign q_job    = hold_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hold_valid_reg <= 1'b0;
        end else if (s_ready) begin
            hold_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            hold_reg.key_index     <= s_data.key_index;
            hold_reg.note_velocity <= s_data.note_velocity;
            hold_reg.in_range      <= in_range;
        end
    end

endmodule

// File: hw/rtl/pae_queue.sv
// short job queue between front end and back end
// depends on pae_pkg

module pae_queue import pae_pkg::*; (
    input  logic aclk,
    input  logic aresetn,
    input  logic push_valid,
    output logic push_ready,
    input  job_t push_job,
    output logic pop_valid,
    input  logic pop_ready,
    output job_t pop_job
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    job_t             slot_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg;
    logic [PTR_W-1:0] rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push;
    logic             do_pop;

    assign push_ready = (count_reg != CNT_W'(QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_job    = slot_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
    endfunction

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (do_push) begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop) begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (do_pop && !do_push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            slot_reg[wr_ptr_reg] <= push_job;
        end
    end

endmodule

// File: hw/rtl/pae_back.sv
// back end: per-key state memory, envelope update and result register
// depends on pae_pkg

module pae_back import pae_pkg::*; (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_we,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [SETTING_W-1:0] cfg_data,
    input  logic                 q_valid,
    output logic                 q_ready,
    input  job_t                 q_job,
    output logic                 m_valid,
    input  logic                 m_ready,
    output out_item_t            m_data
);

    typedef enum logic {
        S_IDLE,
        S_CALC
    } state_t;

    state_t             state_reg;
    job_t               job_reg;
    logic               m_valid_reg;
    out_item_t          m_data_reg;
    logic [SETTING_W-1:0] attack_reg;
    logic [SETTING_W-1:0] decay_reg;
    logic [SETTING_W-1:0] release_reg;

    env_word_t          mem [MEM_DEPTH];
    logic [MEM_DEPTH-1:0] valid_reg;
    env_word_t          rd_word_reg;
    logic               rd_hit_reg;

    logic               pop;
    logic               out_free;
    logic               finish;
    logic               mem_we;
    logic [ADDR_W-1:0]  rd_addr;
    logic [ADDR_W-1:0]  wr_addr;
    env_word_t          cur;
    env_word_t          upd;

    assign q_ready  = (state_reg == S_IDLE);
    assign pop      = q_valid && q_ready;
    assign out_free = !m_valid_reg || m_ready;
    assign finish   = (state_reg == S_CALC) && out_free;
    assign mem_we   = finish && job_reg.in_range;
    assign rd_addr  = q_job.key_index[ADDR_W-1:0];
    assign wr_addr  = job_reg.key_index[ADDR_W-1:0];
    assign cur      = rd_hit_reg ? rd_word_reg : '0;
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;

    // one tick of the envelope
    always_comb begin
        logic [LEVEL_W:0]   sum;
        logic [LEVEL_W-1:0] rise;
        logic [LEVEL_W-1:0] dfall;
        logic [LEVEL_W-1:0] rfall;
        logic [LEVEL_W-1:0] floor_lvl;
        logic               held;
        rise      = LEVEL_W'(attack_reg >> 1);
        dfall     = LEVEL_W'(decay_reg >> 4);
        rfall     = LEVEL_W'(release_reg >> 1);
        floor_lvl = cur.peak >> 1;
        held      = (job_reg.note_velocity != '0);
        sum       = {1'b0, cur.level} + {1'b0, rise};
        upd       = cur;
        case (cur.phase)
            PH_ATTACK: begin
                if (cur.level < cur.peak) begin
                    upd.level = (sum > {1'b0, cur.peak}) ? cur.peak : sum[LEVEL_W-1:0];
                end else begin
                    upd.phase = PH_DECAY;
                end
            end
            PH_DECAY: begin
                if ({cur.level, 1'b0} > {1'b0, cur.peak}) begin
                    if ({1'b0, cur.level} >= ({1'b0, floor_lvl} + {1'b0, dfall})) begin
                        upd.level = cur.level - dfall;
                    end else begin
                        upd.level = floor_lvl;
                    end
                end else begin
                    upd.phase = PH_SUSTAIN;
                end
            end
            PH_SUSTAIN: begin
                if (!held) begin
                    upd.phase = PH_RELEASE;
                end
            end
            PH_RELEASE: begin
                if (held) begin
                    upd.phase = PH_ATTACK;
                    upd.peak  = job_reg.note_velocity;
                end else if (cur.level != '0) begin
                    upd.level = (cur.level > rfall) ? cur.level - rfall : '0;
                end else begin
                    upd.phase = PH_REST;
                    upd.peak  = '0;
                end
            end
            default: begin
                upd.phase = PH_REST;
                if (held) begin
                    upd.phase = PH_ATTACK;
                    upd.peak  = job_reg.note_velocity;
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            m_valid_reg <= 1'b0;
            attack_reg  <= ATTACK_RESET;
            decay_reg   <= DECAY_RESET;
            release_reg <= RELEASE_RESET;
        end else begin
            if (cfg_we) begin
                case (cfg_index)
                    CFG_ATTACK:  attack_reg  <= cfg_data;
                    CFG_DECAY:   decay_reg   <= cfg_data;
                    CFG_RELEASE: release_reg <= cfg_data;
                    default:     ;
                endcase
            end
            if (finish) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            case (state_reg)
                S_IDLE: begin
                    if (pop) begin
                        job_reg   <= q_job;
                        state_reg <= S_CALC;
                    end
                end
                S_CALC: begin
                    if (out_free) begin
                        if (job_reg.in_range) begin
                            m_data_reg.level     <= upd.level;
                            m_data_reg.phase_out <= upd.phase;
                        end else begin
                            m_data_reg <= '0;
                        end
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (mem_we) begin
            valid_reg[wr_addr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[wr_addr] <= upd;
        end
        if (pop) begin
            rd_word_reg <= mem[rd_addr];
            rd_hit_reg  <= valid_reg[rd_addr] && q_job.in_range;
        end
    end

    a_calc_after_pop: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (state_reg == S_CALC))
        else $error("no update cycle after job pop");

    a_write_in_calc: assert property (@(posedge aclk) disable iff (!aresetn)
        mem_we |-> (state_reg == S_CALC) && out_free)
        else $error("state write outside update cycle");

    a_phase_legal: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid_reg |-> (m_data_reg.phase_out <= PH_RELEASE))
        else $error("result phase code out of range");

    a_out_of_range_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (finish && !job_reg.in_range) |=> (m_data_reg == '0))
        else $error("out of range key gave nonzero result");

    a_no_pop_while_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == S_CALC) |-> !pop)
        else $error("job popped while update pending");

endmodule

// File: verif/per_key_adsr_envelope_test.sv
// self-checking testbench for the per-key adsr envelope block
// depends on pae_pkg and per_key_adsr_envelope; predicts each key's envelope tick
// and compares every result transaction under random idle and stall patterns
`timescale 1ns / 100ps

module per_key_adsr_envelope_test;
    import pae_pkg::*;

    localparam int HALF_PERIOD     = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int WATCHDOG_LIMIT  = 2000;
    localparam int SETTLE_CYCLES   = 8;
    localparam int RANDOM_ROUNDS   = 8;
    localparam int ITEMS_PER_ROUND = 250;
    localparam int POOL_SIZE       = 6;

    localparam logic [CFG_IDX_W-1:0] CFG_UNUSED = 2'd3;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_we    = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [SETTING_W-1:0] cfg_data  = '0;
    logic                 s_valid   = 1'b0;
    logic                 s_ready;
    in_item_t             s_data    = '0;
    logic                 m_valid;
    logic                 m_ready   = 1'b0;
    out_item_t            m_data;

    // envelope state as the block should hold it
    phase_t               key_phase [NUM_KEYS];
    logic [LEVEL_W-1:0]   key_level [NUM_KEYS];
    logic [VEL_W-1:0]     key_peak  [NUM_KEYS];
    logic [SETTING_W-1:0] attack_now  = ATTACK_RESET;
    logic [SETTING_W-1:0] decay_now   = DECAY_RESET;
    logic [SETTING_W-1:0] release_now = RELEASE_RESET;

    out_item_t expected_results[$];

    int ticks_accepted  = 0;
    int results_checked = 0;
    int setting_changes = 0;
    int mismatch_count  = 0;
    int quiet_cycles    = 0;
    int stall_mode      = 0;
    int stall_phase     = 0;
    bit bursty_sender   = 1'b0;
    int burst_left      = 1;

    always begin
        #(HALF_PERIOD) aclk = 1'b1;
        #(HALF_PERIOD) aclk = 1'b0;
    end

    per_key_adsr_envelope DUT (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    function automatic out_item_t advance_envelope(input in_item_t item);
        phase_t    ph;
        int        lvl;
        int        pk;
        int        vel;
        int        fall;
        out_item_t res;
        res = '0;
        if (item.key_index >= NUM_KEYS) begin
            return res;
        end
        ph  = key_phase[item.key_index];
        lvl = key_level[item.key_index];
        pk  = key_peak[item.key_index];
        vel = item.note_velocity;
        case (ph)
            PH_ATTACK: begin
                if (lvl < pk) begin
                    lvl = lvl + (attack_now >> 1);
                    if (lvl > pk) lvl = pk;
                end else begin
                    ph = PH_DECAY;
                end
            end
            PH_DECAY: begin
                fall = decay_now >> 4;
                if (2 * lvl > pk) begin
                    lvl = (lvl >= (pk >> 1) + fall) ? lvl - fall : (pk >> 1);
                end else begin
                    ph = PH_SUSTAIN;
                end
            end
            PH_SUSTAIN: begin
                if (vel == 0) ph = PH_SUSTAIN == ph ? PH_RELEASE : ph;
            end
            PH_RELEASE: begin
                fall = release_now >> 1;
                if (vel > 0) begin
                    ph = PH_ATTACK;
                    pk = vel;
                end else if (lvl > 0) begin
                    lvl = (lvl > fall) ? lvl - fall : 0;
                end else begin
                    ph = PH_REST;
                    pk = 0;
                end
            end
            default: begin
                ph = PH_REST;
                if (vel > 0) begin
                    ph = PH_ATTACK;
                    pk = vel;
                end
            end
        endcase
        key_phase[item.key_index] = ph;
        key_level[item.key_index] = LEVEL_W'(lvl);
        key_peak[item.key_index]  = VEL_W'(pk);
        res.level     = LEVEL_W'(lvl);
        res.phase_out = ph;
        return res;
    endfunction

    // predict on input acceptance, compare on output acceptance
    always @(posedge aclk) begin
        out_item_t want;
        if (aresetn) begin
            if (s_valid && s_ready) begin
                expected_results.push_back(advance_envelope(s_data));
                ticks_accepted++;
            end
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    mismatch_count++;
                    $display("%0t unexpected transaction: level %0d phase %0d",
                             $time, m_data.level, m_data.phase_out);
                end else begin
                    want = expected_results.pop_front();
                    results_checked++;
                    if (m_data.level !== want.level) begin
                        mismatch_count++;
                        $display("%0t level mismatch: expected %0d, actual %0d",
                                 $time, want.level, m_data.level);
                    end
                    if (m_data.phase_out !== want.phase_out) begin
                        mismatch_count++;
                        $display("%0t phase mismatch: expected %0d, actual %0d",
                                 $time, want.phase_out, m_data.phase_out);
                    end
                end
            end
        end
    end

    // receiver stall patterns
    always @(posedge aclk) begin
        stall_phase <= stall_phase + 1;
        case (stall_mode)
            1:       m_ready <= 1'($urandom_range(0, 1));
            2:       m_ready <= ($urandom_range(0, 3) == 0);
            3:       m_ready <= ((stall_phase % 7) < 3);
            default: m_ready <= 1'b1;
        endcase
    end

    always @(posedge aclk) begin
        if (!aresetn || (s_valid && s_ready) || (m_valid && m_ready) || cfg_we) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("%0t watchdog: %0d cycles without a transaction", $time, quiet_cycles);
            $display("*** FAILED ***");
            $finish;
        end
    end

    task automatic send_key_tick(input logic [KEY_W-1:0] key, input logic [VEL_W-1:0] vel);
        in_item_t item;
        item.key_index     = key;
        item.note_velocity = vel;
        s_valid <= 1'b1;
        s_data  <= item;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        if (bursty_sender) begin
            burst_left--;
            if (burst_left <= 0) begin
                s_valid <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge aclk);
                burst_left = $urandom_range(1, 16);
            end
        end
    endtask

    task automatic wait_results_drained();
        s_valid <= 1'b0;
        @(posedge aclk);
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    task automatic apply_settings(input logic [SETTING_W-1:0] a, input logic [SETTING_W-1:0] d,
                                  input logic [SETTING_W-1:0] r, input bit poke_unused);
        wait_results_drained();
        cfg_we    <= 1'b1;
        cfg_index <= CFG_ATTACK;
        cfg_data  <= a;
        @(posedge aclk);
        cfg_index <= CFG_DECAY;
        cfg_data  <= d;
        @(posedge aclk);
        cfg_index <= CFG_RELEASE;
        cfg_data  <= r;
        @(posedge aclk);
        if (poke_unused) begin
            cfg_index <= CFG_UNUSED;
            cfg_data  <= SETTING_W'($urandom_range(0, 255));
            @(posedge aclk);
        end
        cfg_we      <= 1'b0;
        attack_now  = a;
        decay_now   = d;
        release_now = r;
        setting_changes++;
    endtask

    function automatic logic [SETTING_W-1:0] pick_setting();
        case ($urandom_range(0, 3))
            0:       return '0;
            1:       return '1;
            default: return SETTING_W'($urandom_range(0, 255));
        endcase
    endfunction

    function automatic logic [VEL_W-1:0] pick_velocity();
        case ($urandom_range(0, 3))
            0:       return '1;
            1:       return VEL_W'(1);
            default: return VEL_W'($urandom_range(1, 255));
        endcase
    endfunction

    // envelope from rest through attack, decay, sustain and into release at the top key with fast rates
    task automatic test_fast_envelope();
        stall_mode    = 0;
        bursty_sender = 1'b0;
        apply_settings('1, '1, '1, 1'b1);
        repeat (3) send_key_tick('1, VEL_W'(30));
        repeat (4) send_key_tick('1, '0);
    endtask

    // zero rates hold decay and attack in place
    task automatic test_zero_rates();
        stall_mode = 1;
        apply_settings('1, '0, '0, 1'b0);
        repeat (5) send_key_tick(KEY_W'(1), VEL_W'(100));
        apply_settings('0, '0, '0, 1'b0);
        repeat (3) send_key_tick('0, '1);
    endtask

    // release parked above the new velocity, then retrigger
    task automatic test_retrigger_above_peak();
        stall_mode = 3;
        apply_settings('1, '1, '0, 1'b0);
        repeat (3) send_key_tick(KEY_W'(8'h5A), VEL_W'(30));
        repeat (4) send_key_tick(KEY_W'(8'h5A), '0);
        repeat (3) send_key_tick(KEY_W'(8'h5A), VEL_W'(4));
    endtask

    // note-on/note-off sequences on a small key pool plus random noise ticks
    task automatic test_random_envelopes();
        logic [KEY_W-1:0] pool_key  [POOL_SIZE];
        logic [VEL_W-1:0] pool_held [POOL_SIZE];
        int               slot;
        int               roll;
        for (int round = 0; round < RANDOM_ROUNDS; round++) begin
            if (round == 0) begin
                apply_settings('1, '1, '1, 1'b0);
            end else begin
                apply_settings(pick_setting(), pick_setting(), pick_setting(),
                               1'($urandom_range(0, 1)));
            end
            stall_mode    = round % 4;
            bursty_sender = (round != 0) && ($urandom_range(0, 3) != 0);
            burst_left    = $urandom_range(1, 16);
            for (int k = 0; k < POOL_SIZE; k++) begin
                pool_key[k]  = KEY_W'($urandom_range(0, 255));
                pool_held[k] = '0;
            end
            for (int n = 0; n < ITEMS_PER_ROUND; n++) begin
                if (n == ITEMS_PER_ROUND / 2) begin
                    wait_results_drained();
                end
                if ($urandom_range(0, 9) == 0) begin
                    send_key_tick(KEY_W'($urandom_range(0, 255)), VEL_W'($urandom_range(0, 255)));
                end else begin
                    slot = $urandom_range(0, POOL_SIZE - 1);
                    roll = $urandom_range(0, 19);
                    if (roll < 2) begin
                        pool_held[slot] = (pool_held[slot] != 0) ? '0 : pick_velocity();
                    end else if (roll == 2 && pool_held[slot] != 0) begin
                        pool_held[slot] = pick_velocity();
                    end
                    send_key_tick(pool_key[slot], pool_held[slot]);
                end
            end
        end
    endtask

    initial begin
        for (int k = 0; k < NUM_KEYS; k++) begin
            key_phase[k] = PH_REST;
            key_level[k] = '0;
            key_peak[k]  = '0;
        end
        repeat (RESET_CYCLES) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_fast_envelope();
        test_zero_rates();
        test_retrigger_above_peak();
        test_random_envelopes();

        wait_results_drained();
        $display("run covered %0d key ticks and %0d checked results over %0d rate settings,",
                 ticks_accepted, results_checked, setting_changes);
        $display("with zero and full-scale rates, retriggers, bursty input and stalled output");
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("*** PASSED ***");
        end else begin
            $display("%0d mismatches, %0d results missing", mismatch_count,
                     expected_results.size());
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule
